// File: rtl/core/bq_pkg.sv
// shared types, constants and microcode program of the biquad filter
package bq_pkg;

  localparam int COEF_W      = 24;
  localparam int NUM_COEFS   = 5;
  localparam int CFG_IDX_W   = 3;

  localparam int SAMPLE_WIDTH_DEF   = 24;
  localparam int COEF_FRAC_BITS_DEF = 21;
  localparam int STATE_WIDTH_DEF    = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    COEF_B0,
    COEF_B1,
    COEF_B2,
    COEF_A1,
    COEF_A2
  } coef_idx_e;

  localparam logic [COEF_W-1:0] COEF_RESET [NUM_COEFS] = '{
    24'd2097152, 24'd0, 24'd0, 24'd0, 24'd0
  };

  typedef enum logic [1:0] {
    COND_NONE,
    COND_IN,
    COND_OUT
  } cond_e;

  typedef enum logic [1:0] {
    SRC_Z1,
    SRC_Z2,
    SRC_U
  } mul_src_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_LOAD_P,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef struct packed {
    cond_e     cond;
    logic      mul_en;
    coef_idx_e mul_coef;
    mul_src_e  mul_src;
    acc_op_e   acc_op;
    logic      u_wr;
    logic      out_wr;
    logic      last;
  } uword_t;

  localparam int NUM_STEPS = 9;
  localparam int STEP_W    = $clog2(NUM_STEPS);

  function automatic uword_t ucode(logic [STEP_W-1:0] step);
    uword_t w;
    w.cond     = COND_NONE;
    w.mul_en   = 1'b0;
    w.mul_coef = COEF_B0;
    w.mul_src  = SRC_Z1;
    w.acc_op   = ACC_HOLD;
    w.u_wr     = 1'b0;
    w.out_wr   = 1'b0;
    w.last     = 1'b0;
    unique case (step)
      4'd0: begin
        w.cond     = COND_IN;
        w.acc_op   = ACC_LOAD_X;
        w.mul_en   = 1'b1;
        w.mul_coef = COEF_A1;
        w.mul_src  = SRC_Z1;
      end
      4'd1: begin
        w.acc_op   = ACC_SUB;
        w.mul_en   = 1'b1;
        w.mul_coef = COEF_A2;
        w.mul_src  = SRC_Z2;
      end
      4'd2: begin
        w.acc_op   = ACC_SUB;
      end
      4'd3: begin
        w.u_wr     = 1'b1;
      end
      4'd4: begin
        w.mul_en   = 1'b1;
        w.mul_coef = COEF_B0;
        w.mul_src  = SRC_U;
      end
      4'd5: begin
        w.acc_op   = ACC_LOAD_P;
        w.mul_en   = 1'b1;
        w.mul_coef = COEF_B1;
        w.mul_src  = SRC_Z1;
      end
      4'd6: begin
        w.acc_op   = ACC_ADD;
        w.mul_en   = 1'b1;
        w.mul_coef = COEF_B2;
        w.mul_src  = SRC_Z2;
      end
      4'd7: begin
        w.acc_op   = ACC_ADD;
      end
      4'd8: begin
        w.cond     = COND_OUT;
        w.out_wr   = 1'b1;
        w.last     = 1'b1;
      end
      default: begin
        w.last     = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/bq_if.sv
// valid/ready word channels for input and output samples
interface bq_in_if #(
  parameter int WIDTH = 24
) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface bq_out_if #(
  parameter int WIDTH = 24
) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// File: rtl/core/biquad_direct_form_two_filter.sv
// biquad direct form II section with microcoded shared-multiplier datapath
//
// usage: samples enter on in_i (valid/ready), one filtered word per input
// leaves on out_o (valid/ready). coefficients b0 b1 b2 a1 a2 (indexes 0..4)
// are written through cfg_we_i/cfg_idx_i/cfg_data_i by the user only while
// the filter is idle; the block does not enforce this. the nine-step microcode
// program runs all five products through one multiplier, feeding an accepted
// word through the a1/a2 feedback into u, then the b0/b1/b2 sum into out_q.
// in_i.ready is high only while the sequencer sits at its first step.
// the result stays in the output register until taken; the next word is
// accepted meanwhile, but the sequencer holds in its last step while the
// output register is still full and out_o.ready is low.
// reset: delays are cleared, b0 returns to 1.0 and the other coefficients to
// zero, the sequencer returns to its first step and the output is empty.
module biquad_direct_form_two_filter
  import bq_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int STATE_WIDTH    = STATE_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0]    cfg_data_i,
  bq_in_if.sink                in_i,
  bq_out_if.source             out_o
);

  localparam int PROD_W = COEF_W + STATE_WIDTH;
  localparam int M0     = (PROD_W > SAMPLE_WIDTH + COEF_FRAC_BITS + 1) ?
                          PROD_W : SAMPLE_WIDTH + COEF_FRAC_BITS + 1;
  localparam int M1     = (M0 > STATE_WIDTH + COEF_FRAC_BITS + 1) ?
                          M0 : STATE_WIDTH + COEF_FRAC_BITS + 1;
  localparam int ACC_W  = M1 + 2;
  localparam int RND_W  = ACC_W - COEF_FRAC_BITS;

  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0] U_MAX =
    {{(RND_W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [RND_W-1:0] U_MIN = ~U_MAX;
  localparam logic signed [RND_W-1:0] Y_MAX =
    {{(RND_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [RND_W-1:0] Y_MIN = ~Y_MAX;

  logic signed [COEF_W-1:0]       coef_q [NUM_COEFS];
  logic signed [STATE_WIDTH-1:0]  z1_q, z2_q, u_q;
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [ACC_W-1:0]        acc_q, acc_d;
  logic [STEP_W-1:0]              step_q, step_d;
  logic                           out_valid_q, out_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] out_q;

  uword_t                         uw;
  logic                           stall, go;
  logic signed [COEF_W-1:0]       mul_a;
  logic signed [STATE_WIDTH-1:0]  mul_b;
  logic signed [ACC_W-1:0]        x_ext, p_ext, rnd_full;
  logic signed [RND_W-1:0]        rnd, u_sat, y_sat;

  assign uw    = ucode(step_q);
  assign stall = ((uw.cond == COND_IN) && !in_i.valid) ||
                 ((uw.cond == COND_OUT) && out_valid_q && !out_o.ready);
  assign go    = !stall;

  assign in_i.ready       = (uw.cond == COND_IN);
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_q;

  // sequencer
  always_comb begin
    if (stall) begin
      step_d = step_q;
    end else if (uw.last) begin
      step_d = '0;
    end else begin
      step_d = step_q + STEP_W'(1);
    end
  end

  // datapath
  assign mul_a = coef_q[uw.mul_coef];

  always_comb begin
    case (uw.mul_src)
      SRC_Z1:  mul_b = z1_q;
      SRC_Z2:  mul_b = z2_q;
      SRC_U:   mul_b = u_q;
      default: mul_b = z1_q;
    endcase
  end

  assign x_ext = {{(ACC_W-SAMPLE_WIDTH){in_i.sample_in[SAMPLE_WIDTH-1]}}, in_i.sample_in}
                 <<< COEF_FRAC_BITS;
  assign p_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    case (uw.acc_op)
      ACC_LOAD_X: acc_d = x_ext;
      ACC_LOAD_P: acc_d = p_ext;
      ACC_ADD:    acc_d = acc_q + p_ext;
      ACC_SUB:    acc_d = acc_q - p_ext;
      default:    acc_d = acc_q;
    endcase
  end

  // round half up, then saturate
  assign rnd_full = acc_q + HALF;
  assign rnd      = rnd_full[ACC_W-1:COEF_FRAC_BITS];
  assign u_sat    = (rnd > U_MAX) ? U_MAX : ((rnd < U_MIN) ? U_MIN : rnd);
  assign y_sat    = (rnd > Y_MAX) ? Y_MAX : ((rnd < Y_MIN) ? Y_MIN : rnd);

  assign out_valid_d = (out_valid_q && !out_o.ready) || (go && uw.out_wr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
      z1_q        <= '0;
      z2_q        <= '0;
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_q[i] <= COEF_RESET[i];
      end
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_COEFS))) begin
        coef_q[cfg_idx_i] <= cfg_data_i;
      end
      if (go && uw.out_wr) begin
        z2_q <= z1_q;
        z1_q <= u_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      acc_q <= acc_d;
    end
    if (go && uw.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (go && uw.u_wr) begin
      u_q <= u_sat[STATE_WIDTH-1:0];
    end
    if (go && uw.out_wr) begin
      out_q <= y_sat[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

// File: sim/tb.sv
// self-checking testbench for the biquad filter: directed table, then random coefficient phases
module tb;
  import bq_pkg::*;

  localparam int SW  = SAMPLE_WIDTH_DEF;
  localparam int CF  = COEF_FRAC_BITS_DEF;
  localparam int STW = STATE_WIDTH_DEF;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 80;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_WORDS    = 90;
  localparam int Q21_ONE        = 1 << CF;
  localparam int STABLE_MARGIN  = 1 << (CF - 4);

  localparam longint HALF_LSB = longint'(1) <<< (CF - 1);

  typedef logic signed [SW-1:0]     smp_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  localparam logic [COEF_W-1:0] V_MAX  = 24'h7FFFFF;
  localparam logic [COEF_W-1:0] V_MIN  = 24'h800000;
  localparam logic [COEF_W-1:0] V_ZERO = 24'h000000;
  localparam logic [COEF_W-1:0] V_ONE  = 24'h000001;
  localparam logic [COEF_W-1:0] V_NEG1 = 24'hFFFFFF;
  localparam logic [COEF_W-1:0] V_TWO  = 24'h000002;
  localparam logic [COEF_W-1:0] V_3    = 24'h000003;
  localparam logic [COEF_W-1:0] V_HALF = 24'h100000;
  localparam logic [COEF_W-1:0] V_JUNK = 24'h5A5A5A;

  localparam logic [CFG_IDX_W-1:0] NO_IDX       = '0;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = CFG_IDX_W'(NUM_COEFS);
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = '1;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [COEF_W-1:0]       data;
    bit                      typed;
    logic [SW-1:0]           want;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COEF_W-1:0]    cfg_data;

  bq_in_if  #(.WIDTH(SW)) in_bus ();
  bq_out_if #(.WIDTH(SW)) out_bus ();

  biquad_direct_form_two_filter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stim_row_t directed_rows [33] = '{
    '{ROW_SAMPLE, NO_IDX, V_ZERO, 1'b1, V_ZERO},
    '{ROW_SAMPLE, NO_IDX, V_MAX,  1'b1, V_MAX},
    '{ROW_SAMPLE, NO_IDX, V_MIN,  1'b1, V_MIN},
    '{ROW_SAMPLE, NO_IDX, V_ONE,  1'b1, V_ONE},
    '{ROW_SAMPLE, NO_IDX, V_NEG1, 1'b1, V_NEG1},
    // output saturation with the largest and smallest gain
    '{ROW_WRITE,  COEF_B0, V_MAX, 1'b0, V_ZERO},
    '{ROW_SAMPLE, NO_IDX, V_MAX,  1'b1, V_MAX},
    '{ROW_SAMPLE, NO_IDX, V_MIN,  1'b1, V_MIN},
    '{ROW_WRITE,  COEF_B0, V_MIN, 1'b0, V_ZERO},
    '{ROW_SAMPLE, NO_IDX, V_MAX,  1'b1, V_MIN},
    '{ROW_SAMPLE, NO_IDX, V_MIN,  1'b1, V_MAX},
    // rounding of exact halves goes up
    '{ROW_WRITE,  COEF_B0, V_HALF, 1'b0, V_ZERO},
    '{ROW_SAMPLE, NO_IDX, V_ONE,  1'b1, V_ONE},
    '{ROW_SAMPLE, NO_IDX, V_NEG1, 1'b1, V_ZERO},
    // writes to unused indexes change nothing
    '{ROW_WRITE,  IDX_SPARE_LO, V_JUNK, 1'b0, V_ZERO},
    '{ROW_WRITE,  IDX_SPARE_HI, V_MAX,  1'b0, V_ZERO},
    '{ROW_SAMPLE, NO_IDX, V_3,    1'b1, V_TWO},
    // unstable feedback drives the state into saturation
    '{ROW_WRITE,  COEF_B1, V_MIN, 1'b0, V_ZERO},
    '{ROW_WRITE,  COEF_B2, V_MAX, 1'b0, V_ZERO},
    '{ROW_WRITE,  COEF_A1, V_MIN, 1'b0, V_ZERO},
    '{ROW_WRITE,  COEF_A2, V_MAX, 1'b0, V_ZERO},
    '{ROW_SAMPLE, NO_IDX, V_MAX, 1'b0, V_ZERO},
    '{ROW_SAMPLE, NO_IDX, V_MAX, 1'b0, V_ZERO},
    '{ROW_SAMPLE, NO_IDX, V_MAX, 1'b0, V_ZERO},
    '{ROW_SAMPLE, NO_IDX, V_MAX, 1'b0, V_ZERO},
    '{ROW_SAMPLE, NO_IDX, V_MAX, 1'b0, V_ZERO},
    '{ROW_SAMPLE, NO_IDX, V_MAX, 1'b0, V_ZERO},
    '{ROW_SAMPLE, NO_IDX, V_MIN, 1'b0, V_ZERO},
    '{ROW_SAMPLE, NO_IDX, V_MIN, 1'b0, V_ZERO},
    '{ROW_SAMPLE, NO_IDX, V_MIN, 1'b0, V_ZERO},
    '{ROW_SAMPLE, NO_IDX, V_MIN, 1'b0, V_ZERO},
    '{ROW_SAMPLE, NO_IDX, V_MIN, 1'b0, V_ZERO},
    '{ROW_SAMPLE, NO_IDX, V_MIN, 1'b0, V_ZERO}
  };

  coef_t  coef_q [NUM_COEFS];
  longint z1_q;
  longint z2_q;
  smp_t   expected_out_q [$];
  smp_t   want_w;

  bit gaps_on;
  bit hold_req;
  int hold_left;
  int quiet_cycles;
  int n_in;
  int n_out;
  int n_err;
  int n_settings;
  int n_holds;

  function automatic longint clamp(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic smp_t biquad_step(input smp_t x);
    longint acc;
    longint u;
    longint y;
    acc = (longint'(x) <<< CF) - longint'(coef_q[COEF_A1]) * z1_q
        - longint'(coef_q[COEF_A2]) * z2_q;
    u = clamp((acc + HALF_LSB) >>> CF, STW);
    acc = longint'(coef_q[COEF_B0]) * u + longint'(coef_q[COEF_B1]) * z1_q
        + longint'(coef_q[COEF_B2]) * z2_q;
    y = clamp((acc + HALF_LSB) >>> CF, SW);
    z2_q = z1_q;
    z1_q = u;
    return smp_t'(y);
  endfunction

  task automatic send_word(input smp_t x, input bit typed, input smp_t want);
    bit done;
    done = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      if (gaps_on && $urandom_range(99) < 19) begin
        in_bus.valid <= 1'b0;
      end else begin
        in_bus.valid     <= 1'b1;
        in_bus.sample_in <= x;
      end
      @(posedge clk_i);
      if (in_bus.valid && in_bus.ready) begin
        want = typed ? want : biquad_step(x);
        if (typed) void'(biquad_step(x));
        expected_out_q.push_back(want);
        n_in++;
        done = 1'b1;
      end
    end
  endtask

  task automatic drain_filter();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    if (idx < NUM_COEFS) coef_q[idx] = coef_t'(val);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [COEF_W-1:0] signed_pick(input int range_lim);
    return COEF_W'(int'($urandom_range(2 * range_lim)) - range_lim);
  endfunction

  function automatic logic [COEF_W-1:0] extreme_pick();
    case ($urandom_range(3))
      0: return V_MIN;
      1: return V_MAX;
      2: return V_ZERO;
      default: return COEF_W'(Q21_ONE);
    endcase
  endfunction

  task automatic pick_coefs(input int mode);
    logic [COEF_W-1:0] c [NUM_COEFS];
    int a2;
    int lim;
    case (mode)
      0: begin
        // stable section: poles inside the unit circle
        a2 = int'($urandom_range(2 * (Q21_ONE - STABLE_MARGIN))) - (Q21_ONE - STABLE_MARGIN);
        lim = Q21_ONE + a2 - STABLE_MARGIN;
        c[COEF_A2] = COEF_W'(a2);
        c[COEF_A1] = signed_pick(lim);
        c[COEF_B0] = signed_pick(Q21_ONE);
        c[COEF_B1] = signed_pick(Q21_ONE);
        c[COEF_B2] = signed_pick(Q21_ONE);
      end
      1: begin
        foreach (c[i]) c[i] = COEF_W'($urandom);
      end
      2: begin
        foreach (c[i]) c[i] = extreme_pick();
      end
      default: begin
        foreach (c[i]) c[i] = signed_pick(Q21_ONE >> 3);
        c[COEF_B0] = COEF_W'($urandom);
      end
    endcase
    for (int i = 0; i < NUM_COEFS; i++) write_coef(CFG_IDX_W'(i), c[i]);
    if ($urandom_range(3) == 0) begin
      write_coef(CFG_IDX_W'(NUM_COEFS + $urandom_range(2)), COEF_W'($urandom));
    end
    n_settings++;
  endtask

  function automatic smp_t random_sample();
    case ($urandom_range(9))
      0: return smp_t'(V_MAX);
      1: return smp_t'(V_MIN);
      2: return smp_t'(int'($urandom_range(512)) - 256);
      3: return smp_t'(int'($urandom_range(1 << 21)) - (1 << 20));
      default: return smp_t'($urandom);
    endcase
  endfunction

  // receiver: random stalls plus the occasional long hold-off
  initial begin
    out_bus.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        n_holds++;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !(gaps_on && $urandom_range(99) < 19);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_out_q.size() == 0) begin
        $display("%0t unexpected word: expected none, got %0d", $time, out_bus.sample_out);
        n_err++;
      end else begin
        want_w = expected_out_q.pop_front();
        if (out_bus.sample_out !== want_w) begin
          $display("%0t sample_out mismatch: expected %0d, got %0d",
                   $time, want_w, out_bus.sample_out);
          n_err++;
        end
        n_out++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t no handshake for %0d cycles, %0d words outstanding",
               $time, WATCHDOG_LIMIT, expected_out_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    in_bus.valid     = 1'b0;
    in_bus.sample_in = '0;
    gaps_on          = 1'b1;
    hold_req         = 1'b0;
    quiet_cycles     = 0;
    n_in             = 0;
    n_out            = 0;
    n_err            = 0;
    n_settings       = 1;
    n_holds          = 0;
    z1_q             = 0;
    z2_q             = 0;
    for (int i = 0; i < NUM_COEFS; i++) coef_q[i] = coef_t'(COEF_RESET[i]);
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        drain_filter();
        write_coef(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_word(smp_t'(directed_rows[i].data), directed_rows[i].typed,
                  smp_t'(directed_rows[i].want));
      end
    end
    n_settings += 4;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      gaps_on = (ph != 1);
      drain_filter();
      pick_coefs(ph == 2 ? 2 : ph == 3 ? 1 : int'($urandom_range(3)));
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if ((ph == 4 || ph == 9) && k == 20) hold_req = 1'b1;
        send_word(random_sample(), 1'b0, '0);
      end
    end

    drain_filter();
    repeat (30) @(posedge clk_i);

    $display("%0d samples filtered and %0d words checked over %0d coefficient settings",
             n_in, n_out, n_settings);
    $display("%0d long receiver hold-offs, %0d mismatches", n_holds, n_err);
    if (n_err == 0 && expected_out_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
